// ===== rtl/rdc_pkg.sv =====
// Package for the radix digit converter: defaults, radix limits, digit glyphs.
`timescale 1ns / 1ps

package rdc_pkg;

  localparam int VALUE_WIDTH_DEF = 64;

  localparam logic [4:0] RADIX_MIN   = 5'd2;
  localparam logic [4:0] RADIX_MAX   = 5'd16;
  localparam logic [4:0] RADIX_RESET = 5'd10;

  typedef logic [3:0] digit_t;
  typedef logic [6:0] glyph_t;

  // ASCII character of one digit value
  function automatic glyph_t digit_glyph(input digit_t d);
    glyph_t g;
    if (d < 4'd10) begin
      g = 7'd48 + {3'd0, d};
    end else begin
      g = 7'd55 + {3'd0, d};
    end
    return g;
  endfunction

  // written base forced into 2..16
  function automatic logic [4:0] clamp_radix(input logic [4:0] v);
    logic [4:0] r;
    if (v < RADIX_MIN) begin
      r = RADIX_MIN;
    end else if (v > RADIX_MAX) begin
      r = RADIX_MAX;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== rtl/radix_digit_converter.sv =====
// Radix digit converter top level: bit-serial base-N conversion with a digit cell chain.
`timescale 1ns / 1ps
// Sequence: an accepted request first shifts the value into the digit cells, MSB first,
//   then shifts the cells out; leading zero cells are skipped and the remaining digits
//   follow one per cycle. busy stays high through both phases, so a new request is taken
//   only after the last digit has left the cells.
// The receiver cannot stall; each digit is on the out_ ports for exactly one cycle.
// Reset (rst_n low, synchronous) idles the block and sets the base to 10.

module radix_digit_converter #(
  parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // request channel
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  // result channel
  output logic                   out_valid,
  output logic [6:0]             out_digit_char,
  output logic                   out_last_digit,
  // base register write
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [4:0]             cfg_radix
);

  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_WIDTH - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   seen_r, seen_nxt;
  logic [4:0]             radix_r;
  logic [VALUE_WIDTH-1:0] shift_r, shift_nxt;
  rdc_pkg::digit_t        cell_r   [VALUE_WIDTH];
  rdc_pkg::digit_t        cell_nxt [VALUE_WIDTH];

  logic                   out_valid_r, out_valid_nxt;
  logic [6:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;

  // doubling step carry chain
  logic [VALUE_WIDTH-1:0] gen, prop, gen_or_prop, carry_in;
  logic [VALUE_WIDTH:0]   carry_sum;
  logic [4:0]             dbl [VALUE_WIDTH];

  logic                   accept;
  logic                   top_nz;
  logic                   at_last;
  logic                   emit_now;

  assign accept    = start && (state_r == ST_IDLE);
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Each conversion cycle doubles the cell chain and adds the next input bit
  // (MSB first). A cell generates a carry when 2d >= radix and passes the
  // incoming carry on when 2d + 1 == radix (odd bases only); the carries
  // resolve as one wide add.
  always_comb begin
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      gen[i]  = ({cell_r[i], 1'b0} >= radix_r);
      prop[i] = ({cell_r[i], 1'b0} + 5'd1 == radix_r);
    end
    gen_or_prop = gen | prop;
    carry_sum   = {1'b0, gen} + {1'b0, gen_or_prop}
                + (VALUE_WIDTH+1)'(shift_r[VALUE_WIDTH-1]);
    carry_in    = carry_sum[VALUE_WIDTH-1:0] ^ gen ^ gen_or_prop;
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      dbl[i] = {cell_r[i], 1'b0} + {4'd0, carry_in[i]};
      if (gen[i] || (prop[i] && carry_in[i])) begin
        dbl[i] = dbl[i] - radix_r;
      end
    end
  end

  assign top_nz   = (cell_r[VALUE_WIDTH-1] != 4'd0);
  assign at_last  = (cnt_r == CNT_LAST);
  // leading zero cells are skipped; the lowest cell always leaves
  assign emit_now = seen_r || top_nz || at_last;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    seen_nxt      = seen_r;
    shift_nxt     = shift_r;
    cell_nxt      = cell_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          shift_nxt = in_value;
          cnt_nxt   = '0;
          for (int i = 0; i < VALUE_WIDTH; i++) begin
            cell_nxt[i] = '0;
          end
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        for (int i = 0; i < VALUE_WIDTH; i++) begin
          cell_nxt[i] = dbl[i][3:0];
        end
        shift_nxt = {shift_r[VALUE_WIDTH-2:0], 1'b0};
        cnt_nxt   = cnt_r + 1'b1;
        if (at_last) begin
          cnt_nxt   = '0;
          seen_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // top cell leaves, the chain moves up one place
        for (int i = VALUE_WIDTH - 1; i > 0; i--) begin
          cell_nxt[i] = cell_r[i-1];
        end
        cell_nxt[0] = '0;
        if (emit_now) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = rdc_pkg::digit_glyph(cell_r[VALUE_WIDTH-1]);
          out_last_nxt  = at_last;
          seen_nxt      = 1'b1;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (at_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      seen_r      <= 1'b0;
      radix_r     <= rdc_pkg::RADIX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      seen_r      <= seen_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        radix_r <= rdc_pkg::clamp_radix(cfg_radix);
      end
    end
  end

  // payload: no reset
  always_ff @(posedge clk) begin
    shift_r    <= shift_nxt;
    cell_r     <= cell_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last_digit = out_last_r;

  // ---------------------------------------------------------------- checks
  a_glyph_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_digit_char >= 7'd48 && out_digit_char <= 7'd57) ||
                   (out_digit_char >= 7'd65 && out_digit_char <= 7'd70)))
    else $error("digit character outside 0-9/A-F");

  a_radix_range: assert property (@(posedge clk) disable iff (!rst_n)
    (radix_r >= rdc_pkg::RADIX_MIN) && (radix_r <= rdc_pkg::RADIX_MAX))
    else $error("stored base outside 2..16");

  a_start_takes: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy && state_r == ST_CONV && cnt_r == '0))
    else $error("request accepted but conversion did not begin");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_digit) |=> !out_valid)
    else $error("digit after the last digit of a run");

  a_no_digit_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |=> !out_valid)
    else $error("digit emitted while converting");

endmodule
